// ===== hw/rtl/dnd_pkg.sv =====
package dnd_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_PARSE   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_MORE = 3'd0;

    // name format constants
    localparam logic [1:0] PTR_TAG        = 2'b11;
    localparam logic [7:0] LEN_MAX        = 8'd63;
    localparam logic [7:0] DOT_CHAR       = 8'h2E;
    localparam logic [3:0] CHARS_PER_WORD = 4'd8;

    // walk position: 14-bit pointer target or store depth, whichever is larger
    localparam int POS_W   = 15;
    localparam int Q_DEPTH = 2;
    localparam int WALK_W  = 8;

    typedef struct packed {
        logic [1:0] operation;
        logic [8:0] msg_address;
        logic [7:0] msg_byte;
        logic [7:0] name_byte;
    } t_in_word;

    typedef struct packed {
        logic [63:0] chars;
        logic [3:0]  char_count;
        logic [2:0]  status;
        logic        last;
    } t_out_word;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_PARSE   = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd_kind;

    // classified command; data is the load byte or the name byte
    typedef struct packed {
        t_cmd_kind  kind;
        logic [8:0] addr;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [3:0] {
        PH_LEN   = 4'b0001,
        PH_PTR   = 4'b0010,
        PH_WORDS = 4'b0100,
        PH_END   = 4'b1000
    } t_phase;

    // event codes match the status codes they report
    typedef enum logic [2:0] {
        EV_GO     = 3'd0,
        EV_DONE   = 3'd1,
        EV_FMT    = 3'd2,
        EV_PAST   = 3'd3,
        EV_BADPTR = 3'd4,
        EV_LIMIT  = 3'd5,
        EV_JUMP   = 3'd6
    } t_event;

    typedef struct packed {
        t_phase      phase;
        logic [5:0]  label_rem;
        logic [5:0]  ptr_high;
        t_event      ev;
        logic [1:0]  n_push;
        logic [13:0] target;
    } t_step;

    // one byte through the label / pointer parser
    function automatic t_step take_byte(t_phase ph, logic [5:0] lr, logic [5:0] hi,
                                        logic [7:0] b);
        t_step s;
        s.phase     = ph;
        s.label_rem = lr;
        s.ptr_high  = hi;
        s.ev        = EV_GO;
        s.n_push    = 2'd0;
        s.target    = {hi, b};
        unique case (ph)
            PH_LEN: begin
                if (b[7:6] == PTR_TAG) begin
                    s.ptr_high = b[5:0];
                    s.phase    = PH_PTR;
                end else if (b > LEN_MAX) begin
                    s.ev = EV_FMT;
                end else if (b != 8'd0) begin
                    s.label_rem = b[5:0];
                    s.phase     = PH_WORDS;
                end else begin
                    s.phase = PH_END;
                    s.ev    = EV_DONE;
                end
            end
            PH_PTR: begin
                s.ptr_high = 6'd0;
                s.phase    = PH_LEN;
                s.ev       = EV_JUMP;
            end
            PH_WORDS: begin
                s.n_push    = 2'd1;
                s.label_rem = lr - 6'd1;
                if (lr == 6'd1) begin
                    s.n_push = 2'd2;
                    s.phase  = PH_LEN;
                end
            end
            default: begin
                s.ev = EV_PAST;
            end
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/dnd_front.sv =====
module dnd_front
    import dnd_pkg::*;
#(
    parameter int MSG_DEPTH = 512
) (
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_word i_in,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic [POS_W-1:0] w_addr_ext;

    assign w_addr_ext = POS_W'(i_in.msg_address);
    assign o_in_stall = i_full;

    // classify the word; unknown ops and out-of-range loads are dropped here
    always_comb begin
        o_cmd.addr = i_in.msg_address;
        o_cmd.data = i_in.msg_byte;
        o_cmd.kind = CMD_LOAD;
        o_push     = 1'b0;
        unique case (i_in.operation)
            OP_LOAD: begin
                o_push = i_in_valid && !i_full && (w_addr_ext < POS_W'(MSG_DEPTH));
            end
            OP_PARSE: begin
                o_cmd.kind = CMD_PARSE;
                o_cmd.data = i_in.name_byte;
                o_push     = i_in_valid && !i_full;
            end
            OP_RESTART: begin
                o_cmd.kind = CMD_RESTART;
                o_push     = i_in_valid && !i_full;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/dnd_queue.sv =====
module dnd_queue
    import dnd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cmd          r_slot [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/dnd_back.sv =====
module dnd_back
    import dnd_pkg::*;
#(
    parameter int MSG_DEPTH = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    input  logic        i_cfg_valid,
    input  logic [7:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out
);

    localparam int AW = $clog2(MSG_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_BYTE = 3'b100
    } t_state;

    // message store
    logic [7:0]        r_mem [MSG_DEPTH];
    logic [7:0]        r_rd_byte;

    t_state            r_state,     n_state;
    t_phase            r_phase,     n_phase;
    logic [5:0]        r_label_rem, n_label_rem;
    logic [5:0]        r_ptr_high,  n_ptr_high;
    logic [WALK_W-1:0] r_walk_cnt,  n_walk_cnt;
    logic [WALK_W-1:0] r_walk_limit;
    logic [POS_W-1:0]  r_pos,       n_pos;
    logic [63:0]       r_pend,      n_pend;
    logic [3:0]        r_pend_cnt,  n_pend_cnt;
    logic              r_out_valid;
    t_out_word         r_out;

    logic              w_out_free;
    logic              w_emit;
    t_out_word         w_res;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [POS_W-1:0]  w_waddr_ext;
    logic [7:0]        w_byte;
    t_step             w_step;
    logic              w_terminal;
    logic [63:0]       w_chars;
    logic [3:0]        w_cnt;
    logic              w_flush;
    logic [63:0]       w_flush_chars;
    logic [7:0]        w_c;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_waddr_ext = POS_W'(i_q_cmd.addr);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // byte source: queued name byte when idle, store byte during a walk
    assign w_byte     = (r_state == S_BYTE) ? r_rd_byte : i_q_cmd.data;
    assign w_step     = take_byte(r_phase, r_label_rem, r_ptr_high, w_byte);
    assign w_terminal = (w_step.ev != EV_GO) && (w_step.ev != EV_JUMP);

    // character packer: up to two pushes, a full word flushes before a push
    always_comb begin
        w_chars       = (r_state == S_BYTE) ? r_pend : 64'd0;
        w_cnt         = (r_state == S_BYTE) ? r_pend_cnt : 4'd0;
        w_flush       = 1'b0;
        w_flush_chars = 64'd0;
        for (int k = 0; k < 2; k++) begin
            w_c = (k == 0) ? w_byte : DOT_CHAR;
            if (2'(k) < w_step.n_push) begin
                if (w_cnt >= CHARS_PER_WORD) begin
                    w_flush       = 1'b1;
                    w_flush_chars = w_chars;
                    w_chars       = 64'd0;
                    w_cnt         = 4'd0;
                end
                w_chars[{w_cnt[2:0], 3'b000} +: 8] = w_c;
                w_cnt = w_cnt + 4'd1;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_label_rem = r_label_rem;
        n_ptr_high  = r_ptr_high;
        n_walk_cnt  = r_walk_cnt;
        n_pos       = r_pos;
        n_pend      = r_pend;
        n_pend_cnt  = r_pend_cnt;
        o_q_pop     = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_emit      = 1'b0;
        w_res       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.kind)
                        CMD_LOAD: begin
                            o_q_pop  = 1'b1;
                            w_mem_we = 1'b1;
                        end
                        CMD_RESTART: begin
                            o_q_pop     = 1'b1;
                            n_phase     = PH_LEN;
                            n_label_rem = 6'd0;
                            n_ptr_high  = 6'd0;
                            n_walk_cnt  = '0;
                        end
                        CMD_PARSE: begin
                            if (w_out_free) begin
                                o_q_pop     = 1'b1;
                                n_phase     = w_step.phase;
                                n_label_rem = w_step.label_rem;
                                n_ptr_high  = w_step.ptr_high;
                                if (w_step.ev == EV_JUMP) begin
                                    n_pos      = POS_W'(w_step.target);
                                    n_walk_cnt = '0;
                                    n_pend     = 64'd0;
                                    n_pend_cnt = 4'd0;
                                    n_state    = S_WALK;
                                end else begin
                                    w_emit           = 1'b1;
                                    w_res.chars      = w_chars;
                                    w_res.char_count = w_cnt;
                                    w_res.status     = w_step.ev;
                                    w_res.last       = 1'b1;
                                end
                            end
                        end
                        default: begin
                            o_q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // range check ranks above the walk limit
                if (r_pos >= POS_W'(MSG_DEPTH) || r_walk_cnt >= r_walk_limit) begin
                    if (w_out_free) begin
                        w_emit           = 1'b1;
                        w_res.chars      = r_pend;
                        w_res.char_count = r_pend_cnt;
                        w_res.status     = (r_pos >= POS_W'(MSG_DEPTH)) ? EV_BADPTR
                                                                         : EV_LIMIT;
                        w_res.last       = 1'b1;
                        n_phase          = PH_END;
                        n_state          = S_IDLE;
                    end
                end else begin
                    w_mem_re   = 1'b1;
                    n_pos      = r_pos + POS_W'(1);
                    n_walk_cnt = r_walk_cnt + WALK_W'(1);
                    n_state    = S_BYTE;
                end
            end
            S_BYTE: begin
                if (!(w_flush || w_terminal) || w_out_free) begin
                    n_phase     = w_terminal ? PH_END : w_step.phase;
                    n_label_rem = w_step.label_rem;
                    n_ptr_high  = w_step.ptr_high;
                    n_pend      = w_chars;
                    n_pend_cnt  = w_cnt;
                    if (w_step.ev == EV_JUMP) begin
                        n_pos = POS_W'(w_step.target);
                    end
                    if (w_flush) begin
                        w_emit           = 1'b1;
                        w_res.chars      = w_flush_chars;
                        w_res.char_count = CHARS_PER_WORD;
                        w_res.status     = STAT_MORE;
                        w_res.last       = 1'b0;
                    end else if (w_terminal) begin
                        w_emit           = 1'b1;
                        w_res.chars      = w_chars;
                        w_res.char_count = w_cnt;
                        w_res.status     = w_step.ev;
                        w_res.last       = 1'b1;
                    end
                    n_state = w_terminal ? S_IDLE : S_WALK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_LEN;
            r_label_rem  <= 6'd0;
            r_ptr_high   <= 6'd0;
            r_walk_cnt   <= '0;
            r_walk_limit <= '1;
            r_pend_cnt   <= 4'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_label_rem <= n_label_rem;
            r_ptr_high  <= n_ptr_high;
            r_walk_cnt  <= n_walk_cnt;
            r_pend_cnt  <= n_pend_cnt;
            if (i_cfg_valid) begin
                r_walk_limit <= i_cfg_data;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_pend <= n_pend;
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_waddr_ext[AW-1:0]] <= i_q_cmd.data;
        end
        if (w_mem_re) begin
            r_rd_byte <= r_mem[r_pos[AW-1:0]];
        end
    end

endmodule

// ===== hw/rtl/dns_name_decompressor.sv =====
// channel  direction  handshake         word
// in       input      i_in_valid/stall  t_in_word: operation, address, bytes
// out      output     o_out_valid/stall t_out_word: chars, count, status, last
// cfg      input      i_cfg_valid/ready walk_limit, 8 bits
//
// A load, restart or direct name byte is taken from the queue and handled in S_IDLE.
// A pointer walk checks the position and reads one stored byte in S_WALK, then
// decodes it in S_BYTE, since the message store has a single registered read port;
// a walk that stops on a bad pointer or on the walk limit reports in S_WALK.
// Reset is synchronous and clears the parser and queue; the store keeps its data.
// The output register frees the back end while a word waits; the back end holds
// only when it must hand over a word; the two-word queue stalls input when full.
module dns_name_decompressor
    import dnd_pkg::*;
#(
    parameter int MSG_DEPTH = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic w_push;
    t_cmd w_push_cmd;
    logic w_full;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_pop;

    assign o_cfg_ready = 1'b1;

    // accept and classify
    dnd_front #(
        .MSG_DEPTH(MSG_DEPTH)
    ) u_front (
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in      (i_in),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    // command queue
    dnd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_push_cmd),
        .o_full (w_full),
        .o_valid(w_q_valid),
        .o_cmd  (w_q_cmd),
        .i_pop  (w_q_pop)
    );

    // store, parser and walker
    dnd_back #(
        .MSG_DEPTH(MSG_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_cmd    (w_q_cmd),
        .o_q_pop    (w_q_pop),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

endmodule
